// File: rtl/sthf_pkg.sv
// ----------------------------------------------------------------------------
// sthf_pkg
// Shared widths and constants for the single-to-half float converter.
// ----------------------------------------------------------------------------
package sthf_pkg;
  localparam int unsigned SINGLE_W = 32;
  localparam int unsigned HALF_W   = 16;
  localparam logic [8:0]  EXP_UF   = 9'd102;  // single exponent 102 -> E = -10
  localparam logic [8:0]  EXP_SUB  = 9'd112;  // single exponent 112 -> E = 0
  localparam logic [8:0]  EXP_OF   = 9'd143;  // single exponent 143 -> E = 31
  localparam logic [14:0] INF_MAG  = 15'h7c00;

  // result class decided in the first stage
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_SUB  = 2'd1,
    CLS_NORM = 2'd2,
    CLS_INF  = 2'd3
  } cls_t;
endpackage

// File: rtl/sthf_stream_if.sv
// ----------------------------------------------------------------------------
// sthf_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sthf_stream_if #(
  parameter int unsigned DATA_W = 32
) ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/single_to_half_float_convert_core.sv
// ----------------------------------------------------------------------------
// single_to_half_float_convert_core
// Converts binary32 bit patterns to binary16 in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in  : sink channel, data = single_bits (32 bits). A beat is taken when
//         valid and ready are both high.
//   out : source channel, data = half_bits (16 bits).
//   Every beat yields exactly one result beat.
//   out.valid rises once the beat has passed the stage 1, 2 and 3 registers.
//   Throughput is one beat per cycle while out.ready stays high; the three pipeline registers set it.
//   Stage 1 classifies and rebiases, stage 2 shifts the subnormal
//   significand, stage 3 rounds subnormal results and assembles the half pattern.
//   When the receiver stalls, the pipeline advances only into empty stages:
//   in.ready drops once all three stages hold data and out.ready is low,
//   nothing is lost or repeated. Reset clears all valid bits; payload is
//   not reset.
// ----------------------------------------------------------------------------
module single_to_half_float_convert_core (
  input  logic               clk,
  input  logic               rst_n,
  sthf_stream_if.sink        in_s,
  sthf_stream_if.source      out_s
);
  // stage 1 registers
  logic               v1_r;
  logic               sgn1_r;
  sthf_pkg::cls_t     cls1_r;
  logic [4:0]         exp1_r;   // normal exponent or subnormal shift amount - 14
  logic [23:0]        sig1_r;
  // stage 2 registers
  logic               v2_r;
  logic               sgn2_r;
  sthf_pkg::cls_t     cls2_r;
  logic [4:0]         exp2_r;
  logic [10:0]        kept2_r;
  logic               rnd2_r;
  logic [9:0]         frac2_r;
  // stage 3 registers
  logic               v3_r;
  logic [15:0]        half3_r;

  logic adv1, adv2, adv3;
  assign adv3 = !v3_r || out_s.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_s.ready = adv1;

  // stage 1: classify and rebias
  logic [8:0]     e_in;
  sthf_pkg::cls_t cls_nxt;
  logic [4:0]     exp_nxt;
  always_comb begin
    e_in = {1'b0, in_s.data[30:23]};
    if (in_s.data[30:0] == 31'd0 || e_in < sthf_pkg::EXP_UF) begin
      cls_nxt = sthf_pkg::CLS_ZERO;
      exp_nxt = 5'd0;
    end else if (e_in <= sthf_pkg::EXP_SUB) begin
      cls_nxt = sthf_pkg::CLS_SUB;
      // shift = 14 - E = 126 - e; stored as 112 - e (0..10)
      exp_nxt = 5'(sthf_pkg::EXP_SUB - e_in);
    end else if (e_in >= sthf_pkg::EXP_OF) begin
      cls_nxt = sthf_pkg::CLS_INF;
      exp_nxt = 5'd0;
    end else begin
      cls_nxt = sthf_pkg::CLS_NORM;
      exp_nxt = 5'(e_in - sthf_pkg::EXP_SUB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_s.valid;
    end
    if (adv1) begin
      sgn1_r <= in_s.data[31];
      cls1_r <= cls_nxt;
      exp1_r <= exp_nxt;
      sig1_r <= {1'b1, in_s.data[22:0]};
    end
  end

  // stage 2: shift significand right by 14 - E (14 + amount, round bit one below)
  logic [23:0] pre_sh;
  always_comb begin
    pre_sh = sig1_r >> exp1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
    if (adv2) begin
      sgn2_r  <= sgn1_r;
      cls2_r  <= cls1_r;
      exp2_r  <= exp1_r;
      kept2_r <= pre_sh[23:13] >> 1;
      rnd2_r  <= pre_sh[13];
      frac2_r <= sig1_r[22:13];
    end
  end

  // stage 3: round subnormals and assemble
  logic [14:0] mag_nxt;
  always_comb begin
    case (cls2_r)
      sthf_pkg::CLS_ZERO: mag_nxt = 15'd0;
      sthf_pkg::CLS_SUB:  mag_nxt = 15'({4'd0, kept2_r} + {14'd0, rnd2_r});
      sthf_pkg::CLS_INF:  mag_nxt = sthf_pkg::INF_MAG;
      sthf_pkg::CLS_NORM: mag_nxt = {exp2_r, frac2_r};
      default:            mag_nxt = 15'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
    if (adv3) begin
      half3_r <= {sgn2_r, mag_nxt};
    end
  end

  assign out_s.valid = v3_r;
  assign out_s.data  = half3_r;

  // assertions
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_s.ready) |-> !in_s.ready)
    else $error("input taken while pipeline full and stalled");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && !out_s.ready) |=> (out_s.valid && $stable(out_s.data)))
    else $error("stalled result changed");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> v1_r)
    else $error("accepted beat lost in stage 1");
  a_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv3 && cls2_r == sthf_pkg::CLS_INF) |=> (half3_r[14:0] == sthf_pkg::INF_MAG))
    else $error("infinity not produced");
endmodule
